FILE: src/cvpt_pkg.sv
// Shared types, constants and helpers of the camera view point test.
package cvpt_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned SumW     = 64;
  localparam int unsigned DimW     = 16;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned ProdW    = SumW + DimW;

  localparam logic signed [SumW-1:0] NearLimitQ16 = 64'sd655;
  localparam logic signed [SumW-1:0] NearLimitQ32 = NearLimitQ16 <<< 16;

  localparam logic [DimW-1:0] WidthReset  = 16'd640;
  localparam logic [DimW-1:0] HeightReset = 16'd480;

  localparam logic [2:0] CfgRow0Xy  = 3'd0;
  localparam logic [2:0] CfgRow0Zw  = 3'd1;
  localparam logic [2:0] CfgRow1Xy  = 3'd2;
  localparam logic [2:0] CfgRow1Zw  = 3'd3;
  localparam logic [2:0] CfgDepthXy = 3'd4;
  localparam logic [2:0] CfgDepthZw = 3'd5;
  localparam logic [2:0] CfgWidth   = 3'd6;
  localparam logic [2:0] CfgHeight  = 3'd7;

  typedef enum logic [1:0] {
    CullNone   = 2'd0,
    CullNear   = 2'd1,
    CullBounds = 2'd2
  } cull_reason_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic                     visible;
    logic [1:0]               cull_reason;
    logic signed [CoordW-1:0] kept_x;
    logic signed [CoordW-1:0] kept_y;
    logic signed [CoordW-1:0] kept_z;
  } out_t;

  typedef struct packed {
    logic [CfgDataW-1:0] row0_xy;
    logic [CfgDataW-1:0] row0_zw;
    logic [CfgDataW-1:0] row1_xy;
    logic [CfgDataW-1:0] row1_zw;
    logic [CfgDataW-1:0] depth_xy;
    logic [CfgDataW-1:0] depth_zw;
    logic [DimW-1:0]     width;
    logic [DimW-1:0]     height;
  } cfg_t;

  function automatic logic signed [SumW-1:0] sat_add(
    input logic signed [SumW-1:0] a,
    input logic signed [SumW-1:0] b
  );
    logic signed [SumW:0]   sum;
    logic signed [SumW-1:0] res;
    sum = {a[SumW-1], a} + {b[SumW-1], b};
    if (sum[SumW] != sum[SumW-1]) begin
      res = sum[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      res = sum[SumW-1:0];
    end
    return res;
  endfunction

endpackage

FILE: src/camera_view_point_test_core.sv
// Camera view point test: pinhole frustum cull of streamed world points.
// Throughput: one point per cycle; six register stages (multiply, three
// saturating adds, bound multiply, compare) advance together while the
// output is not stalled.
// Reset: clears stage valid bits; matrix resets to zero, bounds to 640x480.
module camera_view_point_test_core import cvpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = 6;

  cfg_t                   cfg;
  logic                   en;
  logic [Depth-1:0]       valid_q, valid_d;
  in_t                    kept_q [Depth];
  logic signed [SumW-1:0] a_sum, b_sum, d_sum;
  cull_reason_e           reason;

  cvpt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign en         = !(valid_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;

  assign valid_d = {valid_q[Depth-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kept_q[0] <= in_data_i;
      for (int i = 1; i < Depth; i++) begin
        kept_q[i] <= kept_q[i-1];
      end
    end
  end

  cvpt_row u_row0 (
    .clk_i (clk_i),
    .en_i  (en),
    .xy_i  (cfg.row0_xy),
    .zw_i  (cfg.row0_zw),
    .pt_i  (in_data_i),
    .sum_o (a_sum)
  );

  cvpt_row u_row1 (
    .clk_i (clk_i),
    .en_i  (en),
    .xy_i  (cfg.row1_xy),
    .zw_i  (cfg.row1_zw),
    .pt_i  (in_data_i),
    .sum_o (b_sum)
  );

  cvpt_row u_depth (
    .clk_i (clk_i),
    .en_i  (en),
    .xy_i  (cfg.depth_xy),
    .zw_i  (cfg.depth_zw),
    .pt_i  (in_data_i),
    .sum_o (d_sum)
  );

  cvpt_bound u_bound (
    .clk_i    (clk_i),
    .en_i     (en),
    .a_i      (a_sum),
    .b_i      (b_sum),
    .d_i      (d_sum),
    .width_i  (cfg.width),
    .height_i (cfg.height),
    .reason_o (reason)
  );

  assign out_valid_o            = valid_q[Depth-1];
  assign out_data_o.visible     = (reason == CullNone);
  assign out_data_o.cull_reason = reason;
  assign out_data_o.kept_x      = kept_q[Depth-1].point_x;
  assign out_data_o.kept_y      = kept_q[Depth-1].point_y;
  assign out_data_o.kept_z      = kept_q[Depth-1].point_z;

endmodule

FILE: src/cvpt_cfg.sv
// Configuration register file: projection matrix and image bounds.
module cvpt_cfg import cvpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic hit;

  assign cfg_ready_o = 1'b1;
  assign hit = cfg_valid_i && (cfg_index_i[CfgIdxW-1:3] == '0);

  always_comb begin
    cfg_d = cfg_q;
    if (hit) begin
      unique case (cfg_index_i[2:0])
        CfgRow0Xy:  cfg_d.row0_xy  = cfg_data_i;
        CfgRow0Zw:  cfg_d.row0_zw  = cfg_data_i;
        CfgRow1Xy:  cfg_d.row1_xy  = cfg_data_i;
        CfgRow1Zw:  cfg_d.row1_zw  = cfg_data_i;
        CfgDepthXy: cfg_d.depth_xy = cfg_data_i;
        CfgDepthZw: cfg_d.depth_zw = cfg_data_i;
        CfgWidth:   cfg_d.width    = cfg_data_i[DimW-1:0];
        CfgHeight:  cfg_d.height   = cfg_data_i[DimW-1:0];
        default:    cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{width: WidthReset, height: HeightReset, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/cvpt_row.sv
// One matrix row: multiply stage, then three saturating accumulate stages.
module cvpt_row import cvpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [CfgDataW-1:0]    xy_i,
  input  logic [CfgDataW-1:0]    zw_i,
  input  in_t                    pt_i,
  output logic signed [SumW-1:0] sum_o
);

  logic signed [CoordW-1:0] cx, cy, cz, cw;
  logic signed [SumW-1:0]   px_d, py_d, pz_d, off_d;
  logic signed [SumW-1:0]   px_q, py_q, pz1_q, off1_q;
  logic signed [SumW-1:0]   s2_q, pz2_q, off2_q;
  logic signed [SumW-1:0]   s3_q, off3_q;
  logic signed [SumW-1:0]   s4_q;

  assign cx = xy_i[CoordW-1:0];
  assign cy = xy_i[2*CoordW-1:CoordW];
  assign cz = zw_i[CoordW-1:0];
  assign cw = zw_i[2*CoordW-1:CoordW];

  assign px_d  = cx * pt_i.point_x;
  assign py_d  = cy * pt_i.point_y;
  assign pz_d  = cz * pt_i.point_z;
  assign off_d = {{(SumW-CoordW-16){cw[CoordW-1]}}, cw, 16'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= px_d;
      py_q   <= py_d;
      pz1_q  <= pz_d;
      off1_q <= off_d;
      s2_q   <= sat_add(px_q, py_q);
      pz2_q  <= pz1_q;
      off2_q <= off1_q;
      s3_q   <= sat_add(s2_q, pz2_q);
      off3_q <= off2_q;
      s4_q   <= sat_add(s3_q, off3_q);
    end
  end

  assign sum_o = s4_q;

endmodule

FILE: src/cvpt_bound.sv
// Depth cull and cross-multiplied image bound test, two stages.
module cvpt_bound import cvpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [SumW-1:0] a_i,
  input  logic signed [SumW-1:0] b_i,
  input  logic signed [SumW-1:0] d_i,
  input  logic [DimW-1:0]        width_i,
  input  logic [DimW-1:0]        height_i,
  output cull_reason_e           reason_o
);

  logic                near_q, a_neg_q, b_neg_q;
  logic [SumW-2:0]     a_q, b_q;
  logic [ProdW-1:0]    wd_q, hd_q;
  logic [ProdW-1:0]    a_ext, b_ext;
  cull_reason_e        reason_q, reason_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_q  <= (d_i < NearLimitQ32);
      a_neg_q <= a_i[SumW-1];
      b_neg_q <= b_i[SumW-1];
      a_q     <= a_i[SumW-2:0];
      b_q     <= b_i[SumW-2:0];
      wd_q    <= ProdW'(d_i[SumW-1:0]) * ProdW'(width_i);
      hd_q    <= ProdW'(d_i[SumW-1:0]) * ProdW'(height_i);
    end
  end

  assign a_ext = ProdW'(a_q);
  assign b_ext = ProdW'(b_q);

  always_comb begin
    priority if (near_q) begin
      reason_d = CullNear;
    end else if (!a_neg_q && !b_neg_q && (a_ext < wd_q) && (b_ext < hd_q)) begin
      reason_d = CullNone;
    end else begin
      reason_d = CullBounds;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      reason_q <= reason_d;
    end
  end

  assign reason_o = reason_q;

endmodule

FILE: dv/camera_view_point_test_core_tb.sv
// Self-checking testbench for the camera view point test core.
`timescale 1ns / 1ps

module camera_view_point_test_core_tb import cvpt_pkg::*; ();

  localparam int ClkPeriod  = 8;
  localparam int QuietLimit = 1000;
  localparam int PhaseCount = 8;
  localparam int PhaseLen   = 175;
  localparam logic signed [SumW-1:0] OneQ16 = 64'sd65536;
  localparam logic signed [SumW:0] SumTop = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [SumW:0] SumBot = -65'sh0_8000_0000_0000_0000;

  typedef enum logic [1:0] {SetKeep, SetPinhole, SetExtreme, SetNarrow} setup_e;
  typedef enum logic [1:0] {RigPinhole, RigRandom, RigExtreme} rig_e;

  typedef struct {
    setup_e       setup;
    in_t          pt;
    bit           fixed_exp;
    cull_reason_e why;
  } probe_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  cfg_t   cam_cfg;
  out_t   expected_views[$];
  probe_t probes[$];
  int     errors       = 0;
  int     quiet_cycles = 0;
  bit     calm         = 1'b0;

  camera_view_point_test_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic signed [SumW-1:0] clamp_sum(input logic signed [SumW-1:0] a,
                                                       input logic signed [SumW-1:0] b);
    logic signed [SumW:0] wide;
    wide = (SumW + 1)'(a) + (SumW + 1)'(b);
    if (wide > SumTop) return SumTop[SumW-1:0];
    if (wide < SumBot) return SumBot[SumW-1:0];
    return wide[SumW-1:0];
  endfunction

  function automatic logic signed [SumW-1:0] row_eval(input logic [CfgDataW-1:0] xy,
                                                      input logic [CfgDataW-1:0] zw,
                                                      input in_t p);
    logic signed [SumW-1:0] cx, cy, cz, co, px, py, pz, acc;
    cx  = $signed(xy[31:0]);
    cy  = $signed(xy[63:32]);
    cz  = $signed(zw[31:0]);
    co  = $signed(zw[63:32]);
    px  = $signed(p.point_x);
    py  = $signed(p.point_y);
    pz  = $signed(p.point_z);
    acc = cx * px;
    acc = clamp_sum(acc, cy * py);
    acc = clamp_sum(acc, cz * pz);
    acc = clamp_sum(acc, co * OneQ16);
    return acc;
  endfunction

  // num / den lies in [0, bound) without dividing
  function automatic bit within_span(input logic signed [SumW-1:0] num,
                                     input logic signed [SumW-1:0] den,
                                     input logic [DimW-1:0] bound);
    logic [ProdW-1:0] lim;
    lim = {{DimW{1'b0}}, den} * {{SumW{1'b0}}, bound};
    return (num >= 0) && ({{DimW{1'b0}}, num} < lim);
  endfunction

  function automatic out_t predict_view(input in_t p);
    out_t                   r;
    logic signed [SumW-1:0] dep, ua, vb;
    cull_reason_e           why;
    dep = row_eval(cam_cfg.depth_xy, cam_cfg.depth_zw, p);
    if (dep < NearLimitQ32) begin
      why = CullNear;
    end else begin
      ua  = row_eval(cam_cfg.row0_xy, cam_cfg.row0_zw, p);
      vb  = row_eval(cam_cfg.row1_xy, cam_cfg.row1_zw, p);
      why = (within_span(ua, dep, cam_cfg.width) && within_span(vb, dep, cam_cfg.height)) ?
            CullNone : CullBounds;
    end
    r.visible     = (why == CullNone);
    r.cull_reason = why;
    r.kept_x      = p.point_x;
    r.kept_y      = p.point_y;
    r.kept_z      = p.point_z;
    return r;
  endfunction

  function automatic void note_mismatch(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%t ERROR %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  function automatic logic [31:0] pick_corner_word();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return DimW'($urandom);
    endcase
  endfunction

  function automatic cfg_t draw_rig(input rig_e rig);
    cfg_t        c;
    int unsigned w, h, fx, fy;
    case (rig)
      RigPinhole: begin
        w          = $urandom_range(1, 2000);
        h          = $urandom_range(1, 2000);
        fx         = $urandom_range(w / 4 + 1, w);
        fy         = $urandom_range(h / 4 + 1, h);
        c.row0_xy  = {32'd0, 32'(fx << 16)};
        c.row0_zw  = {32'($urandom_range(0, 131072)) - 32'd65536, 32'((w / 2) << 16)};
        c.row1_xy  = {32'(fy << 16), 32'd0};
        c.row1_zw  = {32'($urandom_range(0, 131072)) - 32'd65536, 32'((h / 2) << 16)};
        c.depth_xy = {32'($urandom_range(0, 2047)) - 32'd1024,
                      32'($urandom_range(0, 2047)) - 32'd1024};
        c.depth_zw = {32'($urandom_range(0, 32768)) - 32'd16384, 32'h0001_0000};
        c.width    = DimW'(w);
        c.height   = DimW'(h);
      end
      RigRandom: begin
        c.row0_xy  = {$urandom, $urandom};
        c.row0_zw  = {$urandom, $urandom};
        c.row1_xy  = {$urandom, $urandom};
        c.row1_zw  = {$urandom, $urandom};
        c.depth_xy = {$urandom, $urandom};
        c.depth_zw = {$urandom, $urandom};
        c.width    = pick_dim();
        c.height   = pick_dim();
      end
      default: begin
        c.row0_xy  = {pick_corner_word(), pick_corner_word()};
        c.row0_zw  = {pick_corner_word(), pick_corner_word()};
        c.row1_xy  = {pick_corner_word(), pick_corner_word()};
        c.row1_zw  = {pick_corner_word(), pick_corner_word()};
        c.depth_xy = {pick_corner_word(), pick_corner_word()};
        c.depth_zw = {pick_corner_word(), pick_corner_word()};
        c.width    = pick_dim();
        c.height   = pick_dim();
      end
    endcase
    return c;
  endfunction

  function automatic in_t draw_point(input rig_e rig);
    in_t         p;
    int unsigned pick, span, lim;
    pick = $urandom_range(0, 99);
    if (rig == RigExtreme) begin
      p.point_x = pick_corner_word();
      p.point_y = pick_corner_word();
      p.point_z = pick_corner_word();
    end else if (rig == RigRandom || pick < 8) begin
      p.point_x = $urandom;
      p.point_y = $urandom;
      p.point_z = $urandom;
    end else if (pick < 18) begin
      p.point_x = $urandom_range(0, 131072) - 65536;
      p.point_y = $urandom_range(0, 131072) - 65536;
      p.point_z = $urandom_range(0, 1310) - 655;
    end else begin
      span      = $urandom_range(300, 50 << 16);
      lim       = span + span / 5;
      p.point_x = $urandom_range(0, 2 * lim) - lim;
      p.point_y = $urandom_range(0, 2 * lim) - lim;
      p.point_z = span;
    end
    return p;
  endfunction

  function automatic void add_probe(input setup_e s, input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input bit fixed_exp = 1'b0,
                                    input cull_reason_e why = CullNone);
    probe_t pr;
    pr.setup      = s;
    pr.pt.point_x = x;
    pr.pt.point_y = y;
    pr.pt.point_z = z;
    pr.fixed_exp  = fixed_exp;
    pr.why        = why;
    probes.insert(probes.size(), pr);
  endfunction

  task automatic send_point(input in_t p, input out_t want);
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_views.insert(expected_views.size(), want);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // hold requests until every pending result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_views.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgIdxW'(CfgRow0Xy):  cam_cfg.row0_xy  = val;
      CfgIdxW'(CfgRow0Zw):  cam_cfg.row0_zw  = val;
      CfgIdxW'(CfgRow1Xy):  cam_cfg.row1_xy  = val;
      CfgIdxW'(CfgRow1Zw):  cam_cfg.row1_zw  = val;
      CfgIdxW'(CfgDepthXy): cam_cfg.depth_xy = val;
      CfgIdxW'(CfgDepthZw): cam_cfg.depth_zw = val;
      CfgIdxW'(CfgWidth):   cam_cfg.width    = val[DimW-1:0];
      CfgIdxW'(CfgHeight):  cam_cfg.height   = val[DimW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_rig(input cfg_t c, input bit poke_unused);
    settle();
    write_reg(CfgIdxW'(CfgRow0Xy), c.row0_xy);
    write_reg(CfgIdxW'(CfgRow0Zw), c.row0_zw);
    write_reg(CfgIdxW'(CfgRow1Xy), c.row1_xy);
    write_reg(CfgIdxW'(CfgRow1Zw), c.row1_zw);
    write_reg(CfgIdxW'(CfgDepthXy), c.depth_xy);
    write_reg(CfgIdxW'(CfgDepthZw), c.depth_zw);
    write_reg(CfgIdxW'(CfgWidth), {$urandom, 16'($urandom), c.width});
    write_reg(CfgIdxW'(CfgHeight), {$urandom, 16'($urandom), c.height});
    if (poke_unused) write_reg(CfgIdxW'($urandom_range(8, 255)), {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : collect
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_views.size() == 0) begin
        errors++;
        $display("%t ERROR unexpected result, expected none actual %h", $time, out_data_o);
      end else begin
        want = expected_views.pop_front();
        note_mismatch("visible", want.visible, out_data_o.visible);
        note_mismatch("cull_reason", want.cull_reason, out_data_o.cull_reason);
        note_mismatch("kept_x", want.kept_x, out_data_o.kept_x);
        note_mismatch("kept_y", want.kept_y, out_data_o.kept_y);
        note_mismatch("kept_z", want.kept_z, out_data_o.kept_z);
      end
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t rig;
    out_t want;
    in_t  pt;
    rig_e kind;

    cam_cfg        = '0;
    cam_cfg.width  = WidthReset;
    cam_cfg.height = HeightReset;

    add_probe(SetKeep, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, CullNear);
    add_probe(SetKeep, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, CullNear);
    add_probe(SetKeep, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, CullNear);
    add_probe(SetKeep, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, CullNear);
    add_probe(SetPinhole, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    add_probe(SetKeep, 32'h0000_0000, 32'h0000_0000, 32'd655);
    add_probe(SetKeep, 32'h0000_0000, 32'h0000_0000, 32'd654, 1'b1, CullNear);
    add_probe(SetKeep, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b1, CullNear);
    add_probe(SetKeep, 32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000);
    add_probe(SetKeep, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    add_probe(SetKeep, 32'h0000_FFFF, 32'h0000_0000, 32'h0001_0000);
    add_probe(SetKeep, 32'hFFFE_FFFF, 32'h0000_0000, 32'h0001_0000);
    add_probe(SetKeep, 32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000);
    add_probe(SetKeep, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
    add_probe(SetKeep, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    add_probe(SetExtreme, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_probe(SetKeep, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_probe(SetKeep, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_probe(SetKeep, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_probe(SetNarrow, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    add_probe(SetKeep, 32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].setup != SetKeep) begin
        rig.row0_xy  = 64'h0000_0000_0140_0000;
        rig.row0_zw  = 64'h0000_0000_0140_0000;
        rig.row1_xy  = 64'h00F0_0000_0000_0000;
        rig.row1_zw  = 64'h0000_0000_00F0_0000;
        rig.depth_xy = 64'h0;
        rig.depth_zw = 64'h0000_0000_0001_0000;
        rig.width    = 16'd640;
        rig.height   = 16'd480;
        if (probes[i].setup == SetExtreme) begin
          rig.row0_xy  = 64'h8000_0000_8000_0000;
          rig.row0_zw  = 64'h8000_0000_8000_0000;
          rig.row1_xy  = 64'h7FFF_FFFF_7FFF_FFFF;
          rig.row1_zw  = 64'h7FFF_FFFF_7FFF_FFFF;
          rig.depth_xy = 64'h7FFF_FFFF_7FFF_FFFF;
          rig.depth_zw = 64'h7FFF_FFFF_7FFF_FFFF;
          rig.width    = 16'hFFFF;
          rig.height   = 16'hFFFF;
        end else if (probes[i].setup == SetNarrow) begin
          rig.width  = 16'd0;
          rig.height = 16'd1;
        end
        load_rig(rig, probes[i].setup == SetNarrow);
      end
      want = predict_view(probes[i].pt);
      if (probes[i].fixed_exp) begin
        want.cull_reason = probes[i].why;
        want.visible     = (probes[i].why == CullNone);
      end
      send_point(probes[i].pt, want);
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      kind = (ph % 2 == 0) ? RigPinhole : ((ph % 4 == 1) ? RigRandom : RigExtreme);
      calm = (ph == 4);
      load_rig(draw_rig(kind), ph % 3 == 1);
      for (int n = 0; n < PhaseLen; n++) begin
        if (ph == 2 && n == 90) settle();
        pt = draw_point(kind);
        send_point(pt, predict_view(pt));
      end
    end

    settle();
    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
src/cvpt_pkg.sv
src/cvpt_cfg.sv
src/cvpt_row.sv
src/cvpt_bound.sv
src/camera_view_point_test_core.sv
dv/camera_view_point_test_core_tb.sv
